// ----- rtl/core/tvis_pkg.sv -----
package tvis_pkg;

  localparam int POS_W  = 17;
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 4;
  localparam int QDEPTH = 4;

  localparam logic [7:0] TAG_NEGATIVE = 8'h10;
  localparam logic [7:0] TAG_BLOB     = 8'h20;

  typedef enum logic [1:0] {
    MODE_INT       = 2'd0,
    MODE_BLOB_HDR  = 2'd1,
    MODE_BLOB_BYTE = 2'd2,
    MODE_SEEK      = 2'd3
  } mode_t;

  // One classified item: cnt output words starting at addr.
  // Word 0 is first, the rest are mag bytes, little endian.
  // cnt of zero means one status-only word.
  typedef struct packed {
    logic [7:0]        first;
    logic [63:0]       mag;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic              ok;
  } job_t;

endpackage

// ----- rtl/core/tvis_front.sv -----
module tvis_front #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tvis_pkg::POS_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic signed [63:0]       value,
  input  logic [tvis_pkg::POS_W-1:0] blob_length,
  input  logic [7:0]               data_byte,
  input  logic [tvis_pkg::POS_W-1:0] location,
  input  logic                     q_full,
  output logic                     push,
  output tvis_pkg::job_t           job
);
  import tvis_pkg::*;

  localparam int unsigned PosMax   = (1 << POS_W) - 1;
  localparam int unsigned CapLimit = (BUFFER_BYTES > PosMax) ? PosMax : BUFFER_BYTES;
  localparam int unsigned CapReset = (CapLimit > 65536) ? 65536 : CapLimit;
  localparam logic [POS_W-1:0] CAP_LIM = CapLimit[POS_W-1:0];
  localparam logic [POS_W-1:0] CAP_RST = CapReset[POS_W-1:0];
  localparam int SUM_W = POS_W + 2;

  logic [POS_W-1:0] cap;
  logic [POS_W-1:0] write_position, write_position_next;
  logic             stream_valid, stream_valid_next;
  logic [POS_W-1:0] payload_remaining, payload_remaining_next;
  logic             payload_fits, payload_fits_next;

  logic [63:0]      uvalue;
  logic [63:0]      mag;
  logic             neg;
  logic [3:0]       size;
  logic [SUM_W-1:0] pos_after;
  logic [SUM_W-1:0] cap_ext;
  logic             fit;
  logic             payload_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    uvalue = $unsigned(value);
    neg    = (mode_t'(mode) == MODE_INT) && uvalue[63];
    if (mode_t'(mode) == MODE_BLOB_HDR) begin
      mag = 64'(blob_length);
    end else if (neg) begin
      mag = ~uvalue + 64'd1;
    end else begin
      mag = uvalue;
    end
    if (mag <= 64'h0000_0000_0000_00FF) begin
      size = 4'd1;
    end else if (mag <= 64'h0000_0000_0000_FFFF) begin
      size = 4'd2;
    end else if (mag <= 64'h0000_0000_FFFF_FFFF) begin
      size = 4'd4;
    end else begin
      size = 4'd8;
    end
    cap_ext    = SUM_W'(cap);
    pos_after  = SUM_W'(write_position) + SUM_W'(1) + SUM_W'(size);
    fit        = pos_after <= cap_ext;
    payload_ok = (pos_after + SUM_W'(blob_length)) <= cap_ext;
  end

  always_comb begin
    write_position_next    = write_position;
    stream_valid_next      = stream_valid;
    payload_remaining_next = payload_remaining;
    payload_fits_next      = payload_fits;
    job.first = 8'd0;
    job.mag   = mag;
    job.addr  = write_position[ADDR_W-1:0];
    job.cnt   = '0;
    case (mode_t'(mode))
      MODE_INT: begin
        payload_remaining_next = '0;
        payload_fits_next      = 1'b0;
        if (fit) begin
          write_position_next = pos_after[POS_W-1:0];
          job.first = {4'd0, size} | (neg ? TAG_NEGATIVE : 8'd0);
          job.cnt   = size + 4'd1;
        end else begin
          stream_valid_next = 1'b0;
        end
      end
      MODE_BLOB_HDR: begin
        payload_remaining_next = blob_length;
        payload_fits_next      = 1'b0;
        if (fit) begin
          write_position_next = pos_after[POS_W-1:0];
          job.first = {4'd0, size} | TAG_BLOB;
          job.cnt   = size + 4'd1;
          if (payload_ok) begin
            payload_fits_next = 1'b1;
          end else begin
            stream_valid_next = 1'b0;
          end
        end else begin
          stream_valid_next = 1'b0;
        end
      end
      MODE_BLOB_BYTE: begin
        if (payload_remaining != '0) begin
          payload_remaining_next = payload_remaining - POS_W'(1);
          if (payload_fits && (write_position < cap)) begin
            write_position_next = write_position + POS_W'(1);
            job.first = data_byte;
            job.cnt   = 4'd1;
          end else if (payload_fits) begin
            // capacity shrank under the payload: drop the rest
            payload_fits_next = 1'b0;
            stream_valid_next = 1'b0;
          end
        end
      end
      MODE_SEEK: begin
        payload_remaining_next = '0;
        payload_fits_next      = 1'b0;
        write_position_next    = location;
      end
      default: begin
      end
    endcase
    job.ok = stream_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap               <= CAP_RST;
      write_position    <= '0;
      stream_valid      <= 1'b1;
      payload_remaining <= '0;
      payload_fits      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= (cfg_data > CAP_LIM) ? CAP_LIM : cfg_data;
      end
      if (push) begin
        write_position    <= write_position_next;
        stream_valid      <= stream_valid_next;
        payload_remaining <= payload_remaining_next;
        payload_fits      <= payload_fits_next;
      end
    end
  end

endmodule

// ----- rtl/core/tvis_queue.sv -----
module tvis_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tvis_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output tvis_pkg::job_t head
);
  import tvis_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             entries [QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full     = count == (PTR_W+1)'(QDEPTH);
  assign nonempty = count != '0;
  assign head     = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QDEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QDEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/tvis_back.sv -----
module tvis_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        nonempty,
  input  tvis_pkg::job_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  byte_out,
  output logic [tvis_pkg::ADDR_W-1:0] byte_addr,
  output logic                        byte_valid,
  output logic                        stream_ok,
  output logic                        last
);
  import tvis_pkg::*;

  logic [CNT_W-1:0] k;
  logic [2:0]       idx;
  logic [7:0]       sel;
  logic             status_only;
  logic             take;

  always_comb begin
    status_only = head.cnt == '0;
    idx         = 3'(k - CNT_W'(1));
    sel         = (k == '0) ? head.first : head.mag[{idx, 3'b000} +: 8];
    out_valid   = nonempty;
    last        = status_only || (k == head.cnt - CNT_W'(1));
    byte_valid  = !status_only;
    byte_out    = status_only ? 8'd0 : sel;
    byte_addr   = status_only ? '0 : head.addr + ADDR_W'(k);
    stream_ok   = head.ok;
    take        = out_valid && out_ready;
    pop         = take && last;
  end

  // advance one word per handshake, retire the item on its last word
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (take) begin
      k <= last ? '0 : k + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/tagged_varsize_int_serializer_unit.sv -----
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (buffer_capacity)
// in      | in        | in_valid/in_ready   | mode, value, blob_length, data_byte, location
// out     | out       | out_valid/out_ready | byte_out, byte_addr, byte_valid, stream_ok, last
//
// The front accepts one input word per cycle while its 4-entry queue has room.
// The back emits one output word per cycle from the queue head while out_ready is
// high: an integer is a tag word plus 1, 2, 4 or 8 bytes, a blob header a tag word
// plus 1, 2 or 4 bytes, and a payload byte, seek or status-only result one word.
// The single-byte output port sets the sustained rate. Reset is synchronous; a
// stalled output holds its word and the front keeps filling the queue.
module tagged_varsize_int_serializer_unit #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tvis_pkg::POS_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic signed [63:0]          value,
  input  logic [tvis_pkg::POS_W-1:0]  blob_length,
  input  logic [7:0]                  data_byte,
  input  logic [tvis_pkg::POS_W-1:0]  location,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  byte_out,
  output logic [tvis_pkg::ADDR_W-1:0] byte_addr,
  output logic                        byte_valid,
  output logic                        stream_ok,
  output logic                        last
);
  import tvis_pkg::*;

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic full;
  logic nonempty;

  tvis_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .value      (value),
    .blob_length(blob_length),
    .data_byte  (data_byte),
    .location   (location),
    .q_full     (full),
    .push       (push),
    .job        (push_job)
  );

  tvis_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (full),
    .nonempty(nonempty),
    .head    (head)
  );

  tvis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_out  (byte_out),
    .byte_addr (byte_addr),
    .byte_valid(byte_valid),
    .stream_ok (stream_ok),
    .last      (last)
  );

endmodule

// ----- rtl/core/tvis_checker.sv -----
module tvis_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_out,
  input logic [15:0] byte_addr,
  input logic        byte_valid,
  input logic        stream_ok,
  input logic        last
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable({byte_out, byte_addr, byte_valid, stream_ok, last}))
    else $error("output word changed while stalled");

  a_status_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && byte_out == 8'd0 && byte_addr == 16'd0)
    else $error("status-only word is not a bare final word");

  a_ok_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !stream_ok |=> !(out_valid && stream_ok))
    else $error("stream_ok set again after a failure");

  a_addr_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && byte_valid && !last |=> out_valid && byte_valid
      && byte_addr == $past(byte_addr) + 16'd1)
    else $error("bytes of one item are not at consecutive addresses");

endmodule

bind tagged_varsize_int_serializer_unit tvis_checker u_tvis_checker (.*);
